/* hw/rtl/soa_pkg.sv */
// Shared types and constants of the slab object allocator.
`default_nettype none
package soa_pkg;
  localparam int         POOL_PAGES = 16;
  localparam int         MAX_SLOTS  = 64;
  localparam logic [1:0] CL_UNOWNED = 2'd0;
  localparam logic [1:0] CL_EMPTY   = 2'd1;
  localparam logic [1:0] CL_PARTIAL = 2'd2;
  localparam logic [1:0] CL_FULL    = 2'd3;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOPAGE  = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;
  localparam logic [1:0] ST_DOUBLE  = 2'd3;
  localparam logic       OP_ALLOC   = 1'b0;
  localparam logic       OP_FREE    = 1'b1;
  localparam logic       REG_OBJS   = 1'b0;
  localparam logic       REG_KEEP   = 1'b1;
endpackage
`default_nettype wire

/* hw/rtl/soa_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none
module soa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* hw/rtl/slab_object_allocator_top.sv */
// Top level of the slab object allocator: sequencer, page tables and slot memory.
// An allocate from a listed page pops its head slot, and unlinks and pushes the page when it
// changes list; a claim first searches for an unowned page and builds its slot free list.
// A free's path depends on its outcome; an allocate with no page left fails after the search.
// The input is ready again in the cycle after the result reaches the output register.
// Synchronous active-low reset clears the page tables; slot taken bits and free links live in
// slot memory and are written when a page is claimed.
`default_nettype none
module slab_object_allocator_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic        in_tuser,   // operation
  input  wire logic [15:0] in_tdata,   // page_index[3:0], object_index[9:4]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // status, granted_page, granted_object, live_objects
);
  localparam int PW = $clog2(soa_pkg::POOL_PAGES + 1);
  localparam int SW = $clog2(soa_pkg::MAX_SLOTS + 1);
  localparam int PA = (soa_pkg::POOL_PAGES > 1) ? $clog2(soa_pkg::POOL_PAGES) : 1;
  localparam int DEPTH = soa_pkg::POOL_PAGES * soa_pkg::MAX_SLOTS;
  localparam int MA = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
  localparam logic [PW-1:0] PNULL = PW'(soa_pkg::POOL_PAGES);
  localparam logic [SW-1:0] SNULL = SW'(soa_pkg::MAX_SLOTS);

  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_BUILD, S_APOP, S_AWAIT, S_AUPD, S_FCHK, S_FTAKE, S_FUPD,
    S_UNLINK, S_PUSH, S_REL, S_DONE
  } state_t;

  state_t state_r;
  logic [6:0] objs_r;
  logic [4:0] keep_r;
  logic [1:0] cls_r [soa_pkg::POOL_PAGES];
  logic [SW-1:0] use_r [soa_pkg::POOL_PAGES];
  logic [SW-1:0] cap_r [soa_pkg::POOL_PAGES];
  logic [SW-1:0] head_r [soa_pkg::POOL_PAGES];
  logic [PW-1:0] nxt_r [soa_pkg::POOL_PAGES];
  logic [PW-1:0] prv_r [soa_pkg::POOL_PAGES];
  logic [PW-1:0] lh_r [3];
  logic [4:0] ecnt_r;
  logic [10:0] live_r;
  logic [PW-1:0] pg_r;
  logic [SW-1:0] obj_r;
  logic [SW-1:0] bump_r;
  logic [1:0] tgt_r;
  logic rel_r;
  logic [1:0] st_r;
  logic [3:0] gp_r;
  logic [5:0] go_r;

  logic ram_we;
  logic [MA-1:0] ram_addr;
  logic [SW:0] ram_wdata, ram_rdata;
  logic [PA-1:0] p;
  logic [SW-1:0] capc;
  logic [MA-1:0] slot_ix;

  soa_ram #(.WIDTH(SW + 1), .DEPTH(DEPTH)) u_links (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign p = pg_r[PA-1:0];
  assign slot_ix = MA'(p * soa_pkg::MAX_SLOTS) + MA'(obj_r);
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    if (objs_r == 7'd0) capc = SW'(1);
    else if (32'(objs_r) > soa_pkg::MAX_SLOTS) capc = SNULL;
    else capc = SW'(objs_r);
  end

  always_comb begin
    ram_we = 1'b0;
    ram_addr = slot_ix;
    ram_wdata = {1'b0, head_r[p]};
    unique case (state_r)
      S_BUILD: begin
        ram_we = 1'b1;
        ram_addr = MA'(p * soa_pkg::MAX_SLOTS) + MA'(bump_r);
        ram_wdata = {1'b0, (bump_r == '0) ? SNULL : bump_r - SW'(1)};
      end
      S_AUPD: begin
        ram_we = 1'b1;
        ram_wdata = {1'b1, ram_rdata[SW-1:0]};
      end
      S_FUPD: ram_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      objs_r <= 7'd64;
      keep_r <= 5'd1;
      out_tvalid <= 1'b0;
      ecnt_r <= '0;
      live_r <= '0;
      for (int i = 0; i < soa_pkg::POOL_PAGES; i++) begin
        cls_r[i] <= soa_pkg::CL_UNOWNED;
        use_r[i] <= '0;
        cap_r[i] <= '0;
        head_r[i] <= SNULL;
        nxt_r[i] <= PNULL;
        prv_r[i] <= PNULL;
      end
      for (int i = 0; i < 3; i++) lh_r[i] <= PNULL;
    end else begin
      if (cfg_we) begin
        if (cfg_index == soa_pkg::REG_OBJS) objs_r <= cfg_wdata;
        else keep_r <= cfg_wdata[4:0];
      end
      if (out_tvalid && out_tready && state_r != S_DONE) out_tvalid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            st_r <= soa_pkg::ST_OK;
            gp_r <= '0;
            go_r <= '0;
            rel_r <= 1'b0;
            if (in_tuser == soa_pkg::OP_FREE) begin
              pg_r <= PW'(in_tdata[3:0]);
              obj_r <= SW'(in_tdata[9:4]);
              state_r <= S_FCHK;
            end else if (lh_r[1] != PNULL) begin
              pg_r <= lh_r[1];
              state_r <= S_APOP;
            end else if (lh_r[0] != PNULL) begin
              pg_r <= lh_r[0];
              state_r <= S_APOP;
            end else begin
              pg_r <= '0;
              state_r <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (pg_r == PNULL) begin
            st_r <= soa_pkg::ST_NOPAGE;
            state_r <= S_DONE;
          end else if (cls_r[p] == soa_pkg::CL_UNOWNED) begin
            cap_r[p] <= capc;
            use_r[p] <= '0;
            bump_r <= capc - SW'(1);
            head_r[p] <= capc - SW'(1);
            nxt_r[p] <= lh_r[0];
            prv_r[p] <= PNULL;
            if (lh_r[0] != PNULL) prv_r[lh_r[0][PA-1:0]] <= pg_r;
            lh_r[0] <= pg_r;
            cls_r[p] <= soa_pkg::CL_EMPTY;
            ecnt_r <= ecnt_r + 5'd1;
            state_r <= S_BUILD;
          end else begin
            pg_r <= pg_r + PW'(1);
          end
        end
        S_BUILD: begin
          if (bump_r == '0) state_r <= S_APOP;
          else bump_r <= bump_r - SW'(1);
        end
        S_APOP: begin
          obj_r <= (head_r[p] >= SNULL) ? '0 : head_r[p];
          state_r <= S_AWAIT;
        end
        S_AWAIT: state_r <= S_AUPD;
        S_AUPD: begin
          head_r[p] <= ram_rdata[SW-1:0];
          use_r[p] <= use_r[p] + SW'(1);
          live_r <= live_r + 11'd1;
          gp_r <= 4'(pg_r);
          go_r <= 6'(obj_r);
          if (use_r[p] + SW'(1) >= cap_r[p]) begin
            if (cls_r[p] == soa_pkg::CL_EMPTY) ecnt_r <= ecnt_r - 5'd1;
            tgt_r <= soa_pkg::CL_FULL;
            state_r <= S_UNLINK;
          end else if (use_r[p] == '0 && cls_r[p] == soa_pkg::CL_EMPTY) begin
            ecnt_r <= ecnt_r - 5'd1;
            tgt_r <= soa_pkg::CL_PARTIAL;
            state_r <= S_UNLINK;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_FCHK: begin
          if (pg_r >= PNULL || cls_r[p] == soa_pkg::CL_UNOWNED || obj_r >= cap_r[p]) begin
            st_r <= soa_pkg::ST_BADFREE;
            state_r <= S_DONE;
          end else begin
            state_r <= S_FTAKE;
          end
        end
        S_FTAKE: begin
          if (!ram_rdata[SW]) begin
            st_r <= soa_pkg::ST_DOUBLE;
            state_r <= S_DONE;
          end else begin
            state_r <= S_FUPD;
          end
        end
        S_FUPD: begin
          head_r[p] <= obj_r;
          if (use_r[p] != '0) use_r[p] <= use_r[p] - SW'(1);
          if (live_r != '0) live_r <= live_r - 11'd1;
          if (use_r[p] <= SW'(1)) begin
            rel_r <= 1'b1;
            if (cls_r[p] != soa_pkg::CL_EMPTY) begin
              ecnt_r <= ecnt_r + 5'd1;
              tgt_r <= soa_pkg::CL_EMPTY;
              state_r <= S_UNLINK;
            end else begin
              state_r <= S_REL;
            end
          end else if (use_r[p] == cap_r[p] && cls_r[p] == soa_pkg::CL_FULL) begin
            tgt_r <= soa_pkg::CL_PARTIAL;
            state_r <= S_UNLINK;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_UNLINK: begin
          if (prv_r[p] != PNULL) nxt_r[prv_r[p][PA-1:0]] <= nxt_r[p];
          else lh_r[cls_r[p] - 2'd1] <= nxt_r[p];
          if (nxt_r[p] != PNULL) prv_r[nxt_r[p][PA-1:0]] <= prv_r[p];
          nxt_r[p] <= PNULL;
          prv_r[p] <= PNULL;
          state_r <= rel_r && tgt_r == soa_pkg::CL_UNOWNED ? S_DONE : S_PUSH;
          if (rel_r && tgt_r == soa_pkg::CL_UNOWNED) begin
            cls_r[p] <= soa_pkg::CL_UNOWNED;
            head_r[p] <= SNULL;
            cap_r[p] <= '0;
            ecnt_r <= ecnt_r - 5'd1;
          end
        end
        S_PUSH: begin
          nxt_r[p] <= lh_r[tgt_r - 2'd1];
          prv_r[p] <= PNULL;
          if (lh_r[tgt_r - 2'd1] != PNULL) prv_r[lh_r[tgt_r - 2'd1][PA-1:0]] <= pg_r;
          lh_r[tgt_r - 2'd1] <= pg_r;
          cls_r[p] <= tgt_r;
          state_r <= rel_r ? S_REL : S_DONE;
        end
        S_REL: begin
          if (ecnt_r > keep_r) begin
            tgt_r <= soa_pkg::CL_UNOWNED;
            state_r <= S_UNLINK;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_tvalid || out_tready) begin
            out_tdata <= {1'b0, live_r, go_r, gp_r, st_r};
            out_tvalid <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the slab object allocator: directed table, then random phases.
`timescale 1ns / 1ps
module tb;

  localparam int PAGES = 16;
  localparam int SLOTS = 64;
  localparam int PG_NIL = PAGES;
  localparam int SL_NIL = SLOTS;
  localparam int QUIET = 120;
  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT = 1000000;
  localparam int PHASE_ITEMS = 142;

  typedef struct packed {
    logic [10:0] live;
    logic [5:0]  gobj;
    logic [3:0]  gpage;
    logic [1:0]  status;
  } grant_t;

  typedef struct {
    bit         is_cfg;
    logic       idx;
    logic [6:0] val;
    int         reps;
    logic       op;
    logic [3:0] pg;
    logic [5:0] obj;
    bit         typed;
    grant_t     want;
  } row_t;

  logic        clk, rst_n;
  logic        cfg_we, cfg_index;
  logic [6:0]  cfg_wdata;
  logic        in_tvalid, in_tready;
  logic        in_tuser;
  logic [15:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [23:0] out_tdata;

  slab_object_allocator_top i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Allocator state as the predictor sees it.
  int unsigned cap_reg, keep_reg;
  logic [1:0]  pg_class [PAGES];
  int unsigned pg_used [PAGES], pg_cap [PAGES], pg_head [PAGES];
  int unsigned pg_next [PAGES], pg_prev [PAGES];
  int unsigned slot_link [PAGES*SLOTS];
  bit          slot_busy [PAGES*SLOTS];
  int unsigned heads [3];
  int unsigned empties, live_cnt;

  grant_t      pending_grants[$];
  logic [9:0]  held_objects[$];
  int          errors = 0;
  int          idle_send = 0, idle_recv = 0;
  bit          hold_req = 0;
  longint      cycles = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic void unlink_page(int unsigned pg);
    int unsigned c, nx, pv;
    c = pg_class[pg];
    nx = pg_next[pg];
    pv = pg_prev[pg];
    if (c == soa_pkg::CL_UNOWNED) return;
    if (pv < PG_NIL) pg_next[pv] = nx;
    else heads[c-1] = nx;
    if (nx < PG_NIL) pg_prev[nx] = pv;
    pg_next[pg] = PG_NIL;
    pg_prev[pg] = PG_NIL;
  endfunction

  function automatic void push_page(int unsigned pg, logic [1:0] c);
    int unsigned h;
    h = heads[c-1];
    pg_next[pg] = h;
    pg_prev[pg] = PG_NIL;
    if (h < PG_NIL) pg_prev[h] = pg;
    heads[c-1] = pg;
    pg_class[pg] = c;
  endfunction

  function automatic void move_to(int unsigned pg, logic [1:0] c);
    unlink_page(pg);
    push_page(pg, c);
  endfunction

  function automatic void clear_allocator();
    cap_reg = 64;
    keep_reg = 1;
    for (int i = 0; i < PAGES; i++) begin
      pg_class[i] = soa_pkg::CL_UNOWNED;
      pg_used[i] = 0;
      pg_cap[i] = 0;
      pg_head[i] = SL_NIL;
      pg_next[i] = PG_NIL;
      pg_prev[i] = PG_NIL;
    end
    for (int i = 0; i < PAGES*SLOTS; i++) begin
      slot_link[i] = 0;
      slot_busy[i] = 0;
    end
    for (int i = 0; i < 3; i++) heads[i] = PG_NIL;
    empties = 0;
    live_cnt = 0;
  endfunction

  function automatic grant_t allocate_or_free(logic op, logic [3:0] pg_in, logic [5:0] obj_in);
    grant_t r;
    int unsigned pg, obj, cap;
    r = '0;
    if (op == soa_pkg::OP_ALLOC) begin
      pg = PG_NIL;
      if (heads[soa_pkg::CL_PARTIAL-1] < PG_NIL) pg = heads[soa_pkg::CL_PARTIAL-1];
      else if (heads[soa_pkg::CL_EMPTY-1] < PG_NIL) pg = heads[soa_pkg::CL_EMPTY-1];
      else begin
        for (int i = PAGES-1; i >= 0; i--)
          if (pg_class[i] == soa_pkg::CL_UNOWNED) pg = i;
        if (pg < PG_NIL) begin
          cap = cap_reg;
          if (cap < 1) cap = 1;
          if (cap > SLOTS) cap = SLOTS;
          pg_cap[pg] = cap;
          pg_used[pg] = 0;
          for (int i = 0; i < cap; i++) slot_link[pg*SLOTS+i] = (i == 0) ? SL_NIL : i - 1;
          pg_head[pg] = cap - 1;
          push_page(pg, soa_pkg::CL_EMPTY);
          empties++;
        end
      end
      if (pg >= PG_NIL) begin
        r.status = soa_pkg::ST_NOPAGE;
      end else begin
        obj = pg_head[pg];
        if (obj >= SL_NIL) obj = 0;
        pg_head[pg] = slot_link[pg*SLOTS+obj];
        slot_busy[pg*SLOTS+obj] = 1;
        pg_used[pg]++;
        live_cnt++;
        if (pg_used[pg] >= pg_cap[pg]) begin
          if (pg_class[pg] == soa_pkg::CL_EMPTY) empties--;
          move_to(pg, soa_pkg::CL_FULL);
        end else if (pg_used[pg] == 1 && pg_class[pg] == soa_pkg::CL_EMPTY) begin
          empties--;
          move_to(pg, soa_pkg::CL_PARTIAL);
        end
        r.status = soa_pkg::ST_OK;
        r.gpage = 4'(pg);
        r.gobj = 6'(obj);
      end
    end else begin
      pg = pg_in;
      obj = obj_in;
      if (pg_class[pg] == soa_pkg::CL_UNOWNED || obj >= pg_cap[pg]) begin
        r.status = soa_pkg::ST_BADFREE;
      end else if (!slot_busy[pg*SLOTS+obj]) begin
        r.status = soa_pkg::ST_DOUBLE;
      end else begin
        slot_link[pg*SLOTS+obj] = pg_head[pg];
        pg_head[pg] = obj;
        slot_busy[pg*SLOTS+obj] = 0;
        if (pg_used[pg] > 0) pg_used[pg]--;
        if (live_cnt > 0) live_cnt--;
        if (pg_used[pg] == 0) begin
          if (pg_class[pg] != soa_pkg::CL_EMPTY) begin
            move_to(pg, soa_pkg::CL_EMPTY);
            empties++;
          end
          if (empties > keep_reg) begin
            unlink_page(pg);
            pg_class[pg] = soa_pkg::CL_UNOWNED;
            pg_head[pg] = SL_NIL;
            pg_cap[pg] = 0;
            empties--;
          end
        end else if (pg_used[pg] + 1 == pg_cap[pg] && pg_class[pg] == soa_pkg::CL_FULL) begin
          move_to(pg, soa_pkg::CL_PARTIAL);
        end
        r.status = soa_pkg::ST_OK;
      end
    end
    r.live = 11'(live_cnt);
    return r;
  endfunction

  // Offers one word, predicts it on acceptance and keeps the list of objects held.
  task automatic send_word(logic op, logic [3:0] pg, logic [5:0] obj, bit typed, grant_t want);
    grant_t g;
    while ($urandom_range(0, 99) < idle_send) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {6'd0, obj, pg};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    g = allocate_or_free(op, pg, obj);
    pending_grants.push_back(typed ? want : g);
    if (op == soa_pkg::OP_ALLOC && g.status == soa_pkg::ST_OK)
      held_objects.push_back({g.gobj, g.gpage});
    if (op == soa_pkg::OP_FREE && g.status == soa_pkg::ST_OK)
      foreach (held_objects[i])
        if (held_objects[i] == {obj, pg}) begin
          held_objects.delete(i);
          break;
        end
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    in_tvalid <= 1'b0;
    wait (pending_grants.size() == 0);
    repeat (QUIET) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == soa_pkg::REG_OBJS) cap_reg = val;
    else keep_reg = val[4:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic row_t item(logic op, logic [3:0] pg, logic [5:0] obj, int reps = 1);
    row_t r;
    r = '{is_cfg: 0, idx: 0, val: 0, reps: reps, op: op, pg: pg, obj: obj, typed: 0, want: '0};
    return r;
  endfunction

  function automatic row_t typed_item(logic op, logic [3:0] pg, logic [5:0] obj,
                                      logic [1:0] st, logic [3:0] gp, logic [5:0] go,
                                      logic [10:0] lv);
    row_t r;
    r = item(op, pg, obj);
    r.typed = 1;
    r.want = '{status: st, gpage: gp, gobj: go, live: lv};
    return r;
  endfunction

  function automatic row_t reg_row(logic idx, logic [6:0] val);
    row_t r;
    r = item(soa_pkg::OP_ALLOC, 0, 0, 0);
    r.is_cfg = 1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  always @(posedge clk) begin
    grant_t got, want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end else if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[22:0];
      if (pending_grants.size() == 0) begin
        errors++;
        $display("%0t: unexpected word %h", $realtime, got);
      end else begin
        want = pending_grants.pop_front();
        if (got.status !== want.status)
          $display("%0t: status expected %0d actual %0d", $realtime, want.status, got.status);
        if (got.gpage !== want.gpage)
          $display("%0t: page expected %0d actual %0d", $realtime, want.gpage, got.gpage);
        if (got.gobj !== want.gobj)
          $display("%0t: object expected %0d actual %0d", $realtime, want.gobj, got.gobj);
        if (got.live !== want.live)
          $display("%0t: live expected %0d actual %0d", $realtime, want.live, got.live);
        if (got !== want) errors++;
      end
    end
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= idle_recv);
      end
    end
  end

  initial begin
    row_t rows[$];
    logic [6:0] objs_set[6] = '{7'd127, 7'd0, 7'd64, 7'd5, 7'd100, 7'd2};
    logic [6:0] keep_set[6] = '{7'd16, 7'd0, 7'd1, 7'd2, 7'd16, 7'd0};
    logic [9:0] pick;
    int r;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tuser = 1'b0;
    in_tdata = '0;
    clear_allocator();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    rows.push_back(typed_item(soa_pkg::OP_ALLOC, 4'hF, 6'h3F, soa_pkg::ST_OK, 0, 63, 1));
    rows.push_back(typed_item(soa_pkg::OP_ALLOC, 0, 0, soa_pkg::ST_OK, 0, 62, 2));
    rows.push_back(typed_item(soa_pkg::OP_FREE, 0, 63, soa_pkg::ST_OK, 0, 0, 1));
    rows.push_back(typed_item(soa_pkg::OP_FREE, 0, 63, soa_pkg::ST_DOUBLE, 0, 0, 1));
    rows.push_back(typed_item(soa_pkg::OP_FREE, 15, 0, soa_pkg::ST_BADFREE, 0, 0, 1));
    rows.push_back(item(soa_pkg::OP_FREE, 0, 62));
    rows.push_back(reg_row(soa_pkg::REG_KEEP, 0));
    rows.push_back(item(soa_pkg::OP_ALLOC, 0, 0));
    rows.push_back(item(soa_pkg::OP_FREE, 0, 62));
    rows.push_back(typed_item(soa_pkg::OP_FREE, 0, 63, soa_pkg::ST_BADFREE, 0, 0, 0));
    rows.push_back(reg_row(soa_pkg::REG_OBJS, 0));
    rows.push_back(item(soa_pkg::OP_ALLOC, 0, 0, 16));
    rows.push_back(typed_item(soa_pkg::OP_ALLOC, 0, 0, soa_pkg::ST_NOPAGE, 0, 0, 16));
    rows.push_back(typed_item(soa_pkg::OP_FREE, 3, 1, soa_pkg::ST_BADFREE, 0, 0, 16));
    rows.push_back(typed_item(soa_pkg::OP_FREE, 15, 63, soa_pkg::ST_BADFREE, 0, 0, 16));
    rows.push_back(item(soa_pkg::OP_FREE, 15, 0));
    rows.push_back(typed_item(soa_pkg::OP_FREE, 15, 0, soa_pkg::ST_BADFREE, 0, 0, 15));
    rows.push_back(item(soa_pkg::OP_ALLOC, 0, 0));
    rows.push_back(item(soa_pkg::OP_FREE, 7, 0));
    rows.push_back(item(soa_pkg::OP_FREE, 7, 0));

    @(negedge clk);
    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_reg(rows[i].idx, rows[i].val);
      else
        repeat (rows[i].reps)
          send_word(rows[i].op, rows[i].pg, rows[i].obj, rows[i].typed, rows[i].want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(soa_pkg::REG_OBJS, objs_set[ph]);
      write_reg(soa_pkg::REG_KEEP, keep_set[ph]);
      idle_send = (ph < 2) ? 28 : (ph < 4) ? 83 : 0;
      idle_recv = (ph < 2) ? 83 : (ph < 4) ? 28 : 0;
      if (ph == 4) hold_req = 1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 50 || held_objects.size() == 0) begin
          send_word(soa_pkg::OP_ALLOC, 4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                    0, '0);
        end else if (r < 88) begin
          pick = held_objects[$urandom_range(0, held_objects.size() - 1)];
          send_word(soa_pkg::OP_FREE, pick[3:0], pick[9:4], 0, '0);
        end else begin
          send_word(soa_pkg::OP_FREE, 4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)),
                    0, '0);
        end
      end
    end

    in_tvalid <= 1'b0;
    wait (pending_grants.size() == 0);
    repeat (QUIET) @(negedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
